[sv/paca_pkg.sv]
// Shared types and constants for the priority array command arbiter.
package paca_pkg;

  // Field widths of the request and result transactions
  localparam int unsigned KindW   = 2;
  localparam int unsigned PrioW   = 8;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned LevelW  = 5;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // Payload kinds
  localparam logic [KindW-1:0] KIND_VALUE = 2'd0;
  localparam logic [KindW-1:0] KIND_NULL  = 2'd1;

  // Level that refuses every write
  localparam logic [PrioW-1:0] DENIED_LEVEL = 8'd6;

  // Reset values of the configuration registers
  localparam logic [ValueW-1:0] NUM_STATES_RESET = 32'd1;
  localparam logic [ValueW-1:0] RELINQ_RESET     = 32'd1;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_NUM_STATES   = 2'd0,
    REG_RELINQ_DFLT  = 2'd1,
    REG_OUT_OF_SERV  = 2'd2
  } cfg_reg_e;

  // Write status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_ARRAY = 3'd1,
    ST_DENIED    = 3'd2,
    ST_RANGE     = 3'd3,
    ST_BAD_DATA  = 3'd4
  } status_e;

  // Held write request
  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [PrioW-1:0]  priority_req;
    logic [ValueW-1:0] value;
    logic              whole_property;
  } req_t;

  // Registered result
  typedef struct packed {
    status_e           status;
    logic [ValueW-1:0] present_value;
    logic [LevelW-1:0] active_level;
    logic              changed;
  } rsp_t;

  // Configuration register contents
  typedef struct packed {
    logic [ValueW-1:0] num_states;
    logic [ValueW-1:0] relinq_dflt;
    logic              out_of_serv;
  } cfg_t;

endpackage

[sv/paca_if.sv]
// Request and result channel interfaces for the priority array command arbiter.
interface paca_req_if;
  logic                          valid;
  logic                          ready;
  logic [paca_pkg::KindW-1:0]    kind;
  logic [paca_pkg::PrioW-1:0]    priority_req;
  logic [paca_pkg::ValueW-1:0]   value;
  logic                          whole_property;

  modport source (output valid, kind, priority_req, value, whole_property, input ready);
  modport sink (input valid, kind, priority_req, value, whole_property, output ready);
endinterface

interface paca_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [paca_pkg::StatusW-1:0]  status;
  logic [paca_pkg::ValueW-1:0]   present_value;
  logic [paca_pkg::LevelW-1:0]   active_level;
  logic                          changed;

  modport source (output valid, status, present_value, active_level, changed, input ready);
  modport sink (input valid, status, present_value, active_level, changed, output ready);
endinterface

[sv/paca_cfg_regs.sv]
// Configuration registers of the priority array command arbiter.
module paca_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [paca_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [paca_pkg::CfgDataW-1:0]  cfg_data_i,
  output paca_pkg::cfg_t                 cfg_o
);

  paca_pkg::cfg_t cfg_q;

  // Write the addressed register, ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_states  <= paca_pkg::NUM_STATES_RESET;
      cfg_q.relinq_dflt <= paca_pkg::RELINQ_RESET;
      cfg_q.out_of_serv <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        paca_pkg::REG_NUM_STATES:  cfg_q.num_states  <= cfg_data_i;
        paca_pkg::REG_RELINQ_DFLT: cfg_q.relinq_dflt <= cfg_data_i;
        paca_pkg::REG_OUT_OF_SERV: cfg_q.out_of_serv <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/paca_in_reg.sv]
// Input register: holds one accepted write transaction until the core takes it.
module paca_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  paca_req_if.sink        req,
  input  logic            take_i,
  output logic            valid_o,
  output paca_pkg::req_t  req_o
);

  logic           valid_q;
  paca_pkg::req_t req_q;
  logic           accept;

  // Free when empty or when the held transaction leaves this cycle
  assign req.ready = !valid_q || take_i;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  // Capture payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.kind           <= req.kind;
      req_q.priority_req   <= req.priority_req;
      req_q.value          <= req.value;
      req_q.whole_property <= req.whole_property;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

[sv/paca_core.sv]
// Priority array state, write checks and arbitration, with the result register.
module paca_core #(
  parameter int unsigned PRIORITY_LEVELS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  paca_pkg::cfg_t  cfg_i,
  input  logic            valid_i,
  input  paca_pkg::req_t  req_i,
  output logic            take_o,
  paca_rsp_if.source      rsp
);

  localparam int unsigned IdxW = $clog2(PRIORITY_LEVELS);
  localparam int unsigned ActW = $clog2(PRIORITY_LEVELS + 1);
  localparam logic [ActW-1:0] ActNone = ActW'(PRIORITY_LEVELS);
  localparam logic [paca_pkg::PrioW-1:0] PrioMax = paca_pkg::PrioW'(PRIORITY_LEVELS);

  logic [paca_pkg::ValueW-1:0] slot_q [PRIORITY_LEVELS];
  logic [PRIORITY_LEVELS-1:0]  valid_q, valid_d;
  logic [ActW-1:0]             act_q, act_d;
  logic [paca_pkg::ValueW-1:0] pres_q, pres_d;
  logic                        out_valid_q;
  paca_pkg::rsp_t              rsp_q, rsp_d;

  logic                        in_range;
  logic [IdxW-1:0]             idx;
  logic [paca_pkg::PrioW-1:0]  prio_m1;
  logic                        slot_we;
  logic                        ffs_hit;
  logic [IdxW-1:0]             ffs_idx;
  paca_pkg::status_e           status;

  // Advance when a transaction is held and the result slot frees up
  assign take_o = valid_i && (!out_valid_q || rsp.ready);

  assign in_range = (req_i.priority_req != '0) && (req_i.priority_req <= PrioMax);
  assign prio_m1  = req_i.priority_req - 8'd1;
  assign idx      = in_range ? prio_m1[IdxW-1:0] : '0;

  // Check the write, then command or relinquish its level
  always_comb begin
    valid_d = valid_q;
    act_d   = act_q;
    pres_d  = pres_q;
    slot_we = 1'b0;
    status  = paca_pkg::ST_OK;
    ffs_hit = 1'b0;
    ffs_idx = '0;
    priority if (!req_i.whole_property) begin
      status = paca_pkg::ST_NOT_ARRAY;
    end else if (req_i.priority_req == paca_pkg::DENIED_LEVEL) begin
      status = paca_pkg::ST_DENIED;
    end else if (req_i.kind != paca_pkg::KIND_VALUE && req_i.kind != paca_pkg::KIND_NULL) begin
      status = paca_pkg::ST_BAD_DATA;
    end else if (req_i.kind == paca_pkg::KIND_VALUE) begin
      if (req_i.value == '0 || req_i.value > cfg_i.num_states) begin
        status = paca_pkg::ST_RANGE;
      end else if (in_range) begin
        slot_we      = 1'b1;
        valid_d[idx] = 1'b1;
        if (ActW'(idx) <= act_q) begin
          act_d  = ActW'(idx);
          pres_d = req_i.value;
        end
      end
    end else if (in_range) begin
      valid_d[idx] = 1'b0;
      if (ActW'(idx) == act_q) begin
        // Fall back to the highest-priority level still valid
        for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
          if (valid_d[i]) begin
            ffs_hit = 1'b1;
            ffs_idx = IdxW'(i);
          end
        end
        if (ffs_hit) begin
          act_d  = ActW'(ffs_idx);
          pres_d = slot_q[ffs_idx];
        end else begin
          act_d  = ActNone;
          pres_d = cfg_i.relinq_dflt;
        end
      end
    end else begin
      // Relinquish of a level outside the array: leave the state alone
    end
    rsp_d.status        = status;
    rsp_d.present_value = pres_d;
    rsp_d.active_level  = paca_pkg::LevelW'(act_d);
    rsp_d.changed       = (pres_d != pres_q) && !cfg_i.out_of_serv;
  end

  // Hold arbitration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      act_q   <= ActNone;
      pres_q  <= paca_pkg::RELINQ_RESET;
    end else if (take_o) begin
      valid_q <= valid_d;
      act_q   <= act_d;
      pres_q  <= pres_d;
    end
  end

  // Store commanded values
  always_ff @(posedge clk_i) begin
    if (take_o && slot_we) begin
      slot_q[idx] <= req_i.value;
    end
  end

  // Result register handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp.valid         = out_valid_q;
  assign rsp.status        = rsp_q.status;
  assign rsp.present_value = rsp_q.present_value;
  assign rsp.active_level  = rsp_q.active_level;
  assign rsp.changed       = rsp_q.changed;

endmodule

[sv/priority_array_command_arbiter.sv]
// Priority array command arbiter: every write transaction passes an input register and
// is checked and arbitrated combinationally into a result register, so the block takes
// one transaction per cycle while the result side is ready; its result passes the input
// register and then the result register. Throughput is bounded by the update of the
// level array, its valid bits, the active level and the present value. Configuration
// writes (number of states, relinquish default, out of service) are registered; a new
// relinquish default only shows once the array falls back to it.
module priority_array_command_arbiter #(
  parameter int unsigned PRIORITY_LEVELS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  paca_req_if.sink                       req,
  paca_rsp_if.source                     rsp,
  input  logic                           cfg_we_i,
  input  logic [paca_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [paca_pkg::CfgDataW-1:0]  cfg_data_i
);

  paca_pkg::cfg_t cfg;
  paca_pkg::req_t held_req;
  logic           held_valid;
  logic           take;

  // Configuration registers
  paca_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Input register
  paca_in_reg u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req),
    .take_i  (take),
    .valid_o (held_valid),
    .req_o   (held_req)
  );

  // Arbitration and result register
  paca_core #(
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (held_valid),
    .req_i   (held_req),
    .take_o  (take),
    .rsp     (rsp)
  );

endmodule

[verif/tb.sv]
// Self-checking testbench for the priority array command arbiter.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned LEVELS         = 16;
  localparam int unsigned HOLD_CYCLES    = 150;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 8;

  // Payload kinds the block cannot decode
  localparam logic [paca_pkg::KindW-1:0] KIND_UNDECODABLE = 2'd2;
  localparam logic [paca_pkg::KindW-1:0] KIND_RESERVED    = 2'd3;

  logic                          clk_i      = 1'b0;
  logic                          rst_ni     = 1'b0;
  logic                          cfg_we_i   = 1'b0;
  logic [paca_pkg::CfgIdxW-1:0]  cfg_idx_i  = paca_pkg::REG_NUM_STATES;
  logic [paca_pkg::CfgDataW-1:0] cfg_data_i = '0;

  // Locally held channel drive
  paca_pkg::req_t req_drv   = '0;
  logic           req_valid = 1'b0;
  logic           rsp_ready = 1'b0;

  paca_req_if req_ch ();
  paca_rsp_if rsp_ch ();

  assign req_ch.valid          = req_valid;
  assign req_ch.kind           = req_drv.kind;
  assign req_ch.priority_req   = req_drv.priority_req;
  assign req_ch.value          = req_drv.value;
  assign req_ch.whole_property = req_drv.whole_property;
  assign rsp_ch.ready          = rsp_ready;

  priority_array_command_arbiter #(
    .PRIORITY_LEVELS(LEVELS)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Shadow of the priority array and its registers
  paca_pkg::cfg_t              shadow_cfg = '{num_states: paca_pkg::NUM_STATES_RESET,
                                              relinq_dflt: paca_pkg::RELINQ_RESET,
                                              out_of_serv: 1'b0};
  logic [paca_pkg::ValueW-1:0] level_slot [LEVELS];
  logic [LEVELS-1:0]           level_set   = '0;
  int unsigned                 active_lvl  = LEVELS;
  logic [paca_pkg::ValueW-1:0] present_val = paca_pkg::RELINQ_RESET;

  paca_pkg::req_t write_queue[$];
  paca_pkg::rsp_t predicted_results[$];
  int   n_queued     = 0;
  int   n_accepted   = 0;
  int   n_errors     = 0;
  int   send_gap_pct = 0;
  int   recv_gap_pct = 0;
  int   hold_ticket  = 0;
  int   hold_seen    = 0;
  int   hold_left    = 0;
  int   quiet_cycles = 0;
  logic req_taken    = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Check one write against the shadow array and apply its effect
  function automatic paca_pkg::rsp_t arbitrate_write(paca_pkg::req_t w);
    paca_pkg::rsp_t              res;
    logic [paca_pkg::ValueW-1:0] prior;
    logic                        in_range;
    int unsigned                 slot;
    int                          i;
    prior    = present_val;
    in_range = (w.priority_req >= 1) && (w.priority_req <= LEVELS);
    slot     = in_range ? w.priority_req - 1 : 0;
    res.status = paca_pkg::ST_OK;
    if (!w.whole_property) begin
      res.status = paca_pkg::ST_NOT_ARRAY;
    end else if (w.priority_req == paca_pkg::DENIED_LEVEL) begin
      res.status = paca_pkg::ST_DENIED;
    end else if (w.kind != paca_pkg::KIND_VALUE && w.kind != paca_pkg::KIND_NULL) begin
      res.status = paca_pkg::ST_BAD_DATA;
    end else if (w.kind == paca_pkg::KIND_VALUE) begin
      if (w.value == '0 || w.value > shadow_cfg.num_states) begin
        res.status = paca_pkg::ST_RANGE;
      end else if (in_range) begin
        level_slot[slot] = w.value;
        level_set[slot]  = 1'b1;
        if (slot <= active_lvl) begin
          active_lvl  = slot;
          present_val = w.value;
        end
      end
    end else if (in_range) begin
      level_set[slot] = 1'b0;
      // Fall back to the next commanded level, else the default
      if (slot == active_lvl) begin
        active_lvl  = LEVELS;
        present_val = shadow_cfg.relinq_dflt;
        for (i = LEVELS - 1; i > int'(slot); i--) begin
          if (level_set[i]) begin
            active_lvl  = i;
            present_val = level_slot[i];
          end
        end
      end
    end
    res.present_value = present_val;
    res.active_level  = paca_pkg::LevelW'(active_lvl);
    res.changed       = (present_val != prior) && !shadow_cfg.out_of_serv;
    return res;
  endfunction

  // Offer queued writes, hold each until it is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!req_valid || req_taken)) begin
      if (write_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        req_drv   <= write_queue.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Drive result ready: random stalls, or a long hold when requested
  always @(negedge clk_i) begin
    if (hold_seen != hold_ticket) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Predict on each accepted write, compare each accepted result
  always @(posedge clk_i) begin
    paca_pkg::rsp_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (predicted_results.size() == 0) begin
        $error("result transaction with no write outstanding");
        n_errors++;
      end else begin
        want = predicted_results.pop_front();
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          n_errors++;
        end
        if (rsp_ch.present_value !== want.present_value) begin
          $error("present_value: expected %h, got %h", want.present_value,
                 rsp_ch.present_value);
          n_errors++;
        end
        if (rsp_ch.active_level !== want.active_level) begin
          $error("active_level: expected %0d, got %0d", want.active_level,
                 rsp_ch.active_level);
          n_errors++;
        end
        if (rsp_ch.changed !== want.changed) begin
          $error("changed: expected %0b, got %0b", want.changed, rsp_ch.changed);
          n_errors++;
        end
      end
    end
    req_taken = rst_ni && req_ch.valid && req_ch.ready;
    if (req_taken) begin
      predicted_results.push_back(arbitrate_write('{kind: req_ch.kind,
                                                    priority_req: req_ch.priority_req,
                                                    value: req_ch.value,
                                                    whole_property: req_ch.whole_property}));
      n_accepted++;
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic paca_pkg::req_t write_req(logic [paca_pkg::KindW-1:0] kind,
                                               logic [paca_pkg::PrioW-1:0] prio,
                                               logic [paca_pkg::ValueW-1:0] value,
                                               logic whole);
    write_req = '{kind: kind, priority_req: prio, value: value, whole_property: whole};
  endfunction

  task automatic queue_write(input paca_pkg::req_t w);
    write_queue.push_back(w);
    n_queued++;
  endtask

  // Wait until every write is taken and every result is back
  task automatic drain();
    while (n_accepted != n_queued || predicted_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input paca_pkg::cfg_reg_e idx,
                           input logic [paca_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    case (idx)
      paca_pkg::REG_NUM_STATES:  shadow_cfg.num_states  = data;
      paca_pkg::REG_RELINQ_DFLT: shadow_cfg.relinq_dflt = data;
      paca_pkg::REG_OUT_OF_SERV: shadow_cfg.out_of_serv = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Reconfigure while idle, then stream mostly well-formed random writes
  task automatic run_phase(input logic [paca_pkg::ValueW-1:0] states,
                           input logic [paca_pkg::ValueW-1:0] dflt,
                           input logic oos, input int sgap, input int rgap,
                           input int count, input bit squeeze);
    paca_pkg::req_t w;
    int             n;
    int unsigned    roll;
    drain();
    write_reg(paca_pkg::REG_NUM_STATES, states);
    write_reg(paca_pkg::REG_RELINQ_DFLT, dflt);
    write_reg(paca_pkg::REG_OUT_OF_SERV, paca_pkg::CfgDataW'(oos));
    @(posedge clk_i);
    send_gap_pct = sgap;
    recv_gap_pct = rgap;
    if (squeeze) hold_ticket++;
    for (n = 0; n < count; n++) begin
      w.whole_property = ($urandom_range(99) >= 6);
      roll = $urandom_range(99);
      if (roll < 85) w.priority_req = paca_pkg::PrioW'($urandom_range(LEVELS, 1));
      else if (roll < 88) w.priority_req = '0;
      else if (roll < 95) w.priority_req = paca_pkg::PrioW'($urandom_range(255, LEVELS + 1));
      else w.priority_req = paca_pkg::PrioW'($urandom());
      roll = $urandom_range(99);
      if (roll < 58) w.kind = paca_pkg::KIND_VALUE;
      else if (roll < 92) w.kind = paca_pkg::KIND_NULL;
      else w.kind = paca_pkg::KindW'($urandom_range(KIND_RESERVED, KIND_UNDECODABLE));
      roll = $urandom_range(99);
      if (w.kind == paca_pkg::KIND_VALUE && roll < 86) w.value = $urandom_range(states, 1);
      else if (roll < 93) w.value = '0;
      else w.value = $urandom();
      queue_write(w);
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: only value 1 is legal
    @(posedge clk_i);
    queue_write(write_req(paca_pkg::KIND_VALUE, 8'd4, 32'd1, 1'b1));
    queue_write(write_req(paca_pkg::KIND_VALUE, 8'd4, 32'd2, 1'b1));
    queue_write(write_req(paca_pkg::KIND_NULL, 8'd4, 32'd0, 1'b1));
    drain();

    write_reg(paca_pkg::REG_NUM_STATES, 32'd100);
    write_reg(paca_pkg::REG_RELINQ_DFLT, 32'd77);
    write_reg(paca_pkg::REG_OUT_OF_SERV, '0);
    @(posedge clk_i);
    // Check order: array form outranks the denied level and bad payloads
    queue_write(write_req(KIND_UNDECODABLE, paca_pkg::DENIED_LEVEL, 32'd5, 1'b0));
    queue_write(write_req(KIND_UNDECODABLE, paca_pkg::DENIED_LEVEL, 32'd5, 1'b1));
    queue_write(write_req(KIND_UNDECODABLE, 8'd3, 32'd5, 1'b1));
    queue_write(write_req(KIND_RESERVED, 8'd3, 32'hFFFF_FFFF, 1'b1));
    // Out-of-range values
    queue_write(write_req(paca_pkg::KIND_VALUE, 8'd3, 32'd0, 1'b1));
    queue_write(write_req(paca_pkg::KIND_VALUE, 8'd3, 32'd101, 1'b1));
    queue_write(write_req(paca_pkg::KIND_VALUE, 8'd3, 32'hFFFF_FFFF, 1'b1));
    // Take over from higher levels, store a lower-priority value
    queue_write(write_req(paca_pkg::KIND_VALUE, 8'd16, 32'd100, 1'b1));
    queue_write(write_req(paca_pkg::KIND_VALUE, 8'd8, 32'd5, 1'b1));
    queue_write(write_req(paca_pkg::KIND_VALUE, 8'd10, 32'd9, 1'b1));
    queue_write(write_req(paca_pkg::KIND_VALUE, 8'd1, 32'd1, 1'b1));
    // Relinquish an inactive level, then the active one
    queue_write(write_req(paca_pkg::KIND_NULL, 8'd10, 32'd0, 1'b1));
    queue_write(write_req(paca_pkg::KIND_NULL, 8'd1, 32'd0, 1'b1));
    // Levels outside the array pass with no effect; a relinquish of the denied level is refused
    queue_write(write_req(paca_pkg::KIND_VALUE, 8'd0, 32'd3, 1'b1));
    queue_write(write_req(paca_pkg::KIND_VALUE, 8'd17, 32'd3, 1'b1));
    queue_write(write_req(paca_pkg::KIND_NULL, 8'd255, 32'd0, 1'b1));
    queue_write(write_req(paca_pkg::KIND_NULL, paca_pkg::DENIED_LEVEL, 32'd0, 1'b1));
    // Fall back to the lowest level, then to the default
    queue_write(write_req(paca_pkg::KIND_NULL, 8'd8, 32'd0, 1'b1));
    queue_write(write_req(paca_pkg::KIND_NULL, 8'd16, 32'd0, 1'b1));
    // Same value on a new level: no change pulse
    queue_write(write_req(paca_pkg::KIND_VALUE, 8'd3, 32'd77, 1'b1));
    queue_write(write_req(paca_pkg::KIND_VALUE, 8'd3, 32'd100, 1'b1));
    queue_write(write_req(paca_pkg::KIND_NULL, 8'd3, 32'd0, 1'b1));
    drain();

    // Out of service hides the pulse; a new default shows only on fall-back
    write_reg(paca_pkg::REG_OUT_OF_SERV, paca_pkg::CfgDataW'(1));
    write_reg(paca_pkg::REG_RELINQ_DFLT, 32'hFFFF_FFFF);
    @(posedge clk_i);
    queue_write(write_req(paca_pkg::KIND_VALUE, 8'd2, 32'd50, 1'b1));
    queue_write(write_req(paca_pkg::KIND_NULL, 8'd2, 32'd0, 1'b1));

    run_phase(32'd1, 32'd1, 1'b0, 0, 0, 140, 1'b0);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 72, 0, 200, 1'b0);
    run_phase(32'd7, 32'd3, 1'b1, 0, 72, 200, 1'b0);
    run_phase(32'd20, 32'd1, 1'b0, 13, 13, 200, 1'b0);
    run_phase(32'd1000, 32'd500, 1'b0, 0, 0, 120, 1'b1);
    run_phase($urandom_range(64, 1), $urandom_range(64, 1), 1'($urandom_range(1)),
              13, 13, 250, 1'b0);

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
